[hw/rtl/e2q_pkg.sv]
// Package for the Euler-to-quaternion converter: word types, fixed-point widths,
// CORDIC constants and the single CORDIC micro-rotation. No dependencies.
package e2q_pkg;

    localparam int ANGLE_W         = 16;
    localparam int QUAT_W          = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int XY_W            = 33;   // Q30 cosine and sine with headroom
    localparam int Z_W             = 19;   // Q16 residual angle
    localparam int TRIG_W          = 18;   // Q15 cosine and sine
    localparam int PAIR_W          = 2 * TRIG_W;
    localparam int TRIPLE_W        = PAIR_W + TRIG_W;
    localparam int SUM_W           = TRIPLE_W + 1;
    localparam int RND_W           = SUM_W - 31;

    // fold register, CORDIC stages, rounding register
    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    // pair products, triple products, sums, rounding, saturation
    localparam int PROD_LAT   = 5;
    localparam int TOTAL_LAT  = CORDIC_LAT + PROD_LAT;

    localparam logic signed [Z_W-1:0]  HALF_PI_Q16     = 19'sd102944;
    localparam logic signed [Z_W-1:0]  NEG_HALF_PI_Q16 = -19'sd102944;
    localparam logic signed [Z_W-1:0]  PI_Q16          = 19'sd205887;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [QUAT_W-1:0] QUAT_ONE      = 16'sd16384;
    localparam logic signed [QUAT_W-1:0] QUAT_NEG_ONE  = -16'sd16384;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_out_word;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } t_cordic_state;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q15;
        logic signed [TRIG_W-1:0] sin_q15;
    } t_trig;

    // atan(2^-i) in Q16, rounded to nearest except for idx 1, which is truncated
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] idx);
        logic signed [Z_W-1:0] a;
        unique case (idx)
            4'd0:  a = 19'sd51472;
            4'd1:  a = 19'sd30385;
            4'd2:  a = 19'sd16055;
            4'd3:  a = 19'sd8150;
            4'd4:  a = 19'sd4091;
            4'd5:  a = 19'sd2047;
            4'd6:  a = 19'sd1024;
            4'd7:  a = 19'sd512;
            4'd8:  a = 19'sd256;
            4'd9:  a = 19'sd128;
            4'd10: a = 19'sd64;
            4'd11: a = 19'sd32;
            4'd12: a = 19'sd16;
            4'd13: a = 19'sd8;
            4'd14: a = 19'sd4;
            4'd15: a = 19'sd2;
        endcase
        return a;
    endfunction

    // One micro-rotation; idx is always a constant at the call site, so the
    // shifts are plain wiring.
    function automatic t_cordic_state cordic_iter(input t_cordic_state s,
                                                  input logic [3:0] idx);
        t_cordic_state          r;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  a;
        r  = s;
        dx = s.y >>> idx;
        dy = s.x >>> idx;
        a  = atan_q16(idx);
        if (!s.z[Z_W-1]) begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - a;
        end else begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + a;
        end
        return r;
    endfunction

endpackage

[hw/rtl/e2q_cordic.sv]
// Pipelined half-angle cosine and sine: range fold, eight CORDIC stages of two
// micro-rotations each, then sign restore and rounding to Q15. Uses e2q_pkg.
module e2q_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_angle,
    output e2q_pkg::t_trig                     o_trig
);

    e2q_pkg::t_cordic_state r_stage [0:e2q_pkg::CORDIC_STAGES];
    e2q_pkg::t_cordic_state n_fold;
    e2q_pkg::t_trig         r_trig;
    e2q_pkg::t_trig         n_trig;
    logic signed [e2q_pkg::Z_W-1:0] z_in;

    // The raw Q13 angle read as Q14 is the half angle; times four gives Q16.
    always_comb begin
        z_in        = {{(e2q_pkg::Z_W - e2q_pkg::ANGLE_W - 2){i_angle[e2q_pkg::ANGLE_W-1]}},
                       i_angle, 2'b00};
        n_fold.x    = e2q_pkg::CORDIC_GAIN_Q30;
        n_fold.y    = '0;
        n_fold.z    = z_in;
        n_fold.flip = 1'b0;
        if (z_in > e2q_pkg::HALF_PI_Q16) begin
            n_fold.z    = z_in - e2q_pkg::PI_Q16;
            n_fold.flip = 1'b1;
        end else if (z_in < e2q_pkg::NEG_HALF_PI_Q16) begin
            n_fold.z    = z_in + e2q_pkg::PI_Q16;
            n_fold.flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage[0] <= n_fold;
        end
    end

    for (genvar g = 0; g < e2q_pkg::CORDIC_STAGES; g++) begin : g_stage
        e2q_pkg::t_cordic_state n_stage;

        always_comb begin
            n_stage = r_stage[g];
            for (int j = 0; j < e2q_pkg::STEPS_PER_STAGE; j++) begin
                n_stage = e2q_pkg::cordic_iter(n_stage,
                                               4'(g * e2q_pkg::STEPS_PER_STAGE + j));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stage[g+1] <= n_stage;
            end
        end
    end

    // Round half away from zero to Q15: bias is half an LSB, one less when negative.
    function automatic logic signed [e2q_pkg::TRIG_W-1:0] round_q15(
        input logic signed [e2q_pkg::XY_W-1:0] v
    );
        logic signed [e2q_pkg::XY_W-1:0] biased;
        biased = v + (v[e2q_pkg::XY_W-1] ? 33'sd16383 : 33'sd16384);
        return biased[e2q_pkg::TRIG_W+14:15];
    endfunction

    always_comb begin
        logic signed [e2q_pkg::XY_W-1:0] c;
        logic signed [e2q_pkg::XY_W-1:0] s;
        c = r_stage[e2q_pkg::CORDIC_STAGES].x;
        s = r_stage[e2q_pkg::CORDIC_STAGES].y;
        if (r_stage[e2q_pkg::CORDIC_STAGES].flip) begin
            c = -c;
            s = -s;
        end
        n_trig.cos_q15 = round_q15(c);
        n_trig.sin_q15 = round_q15(s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

endmodule

[hw/rtl/e2q_product.sv]
// Quaternion assembly: pair products, triple products, sums and differences,
// rounding to Q14 and saturation, one register stage each. Uses e2q_pkg.
module e2q_product (
    input  logic               i_clk,
    input  logic               i_en,
    input  e2q_pkg::t_trig     i_yaw,
    input  e2q_pkg::t_trig     i_pitch,
    input  e2q_pkg::t_trig     i_roll,
    output e2q_pkg::t_out_word o_quat
);

    // pair products and the delayed yaw terms
    logic signed [e2q_pkg::PAIR_W-1:0]   r_cc, r_ss, r_sc, r_cs;
    logic signed [e2q_pkg::PAIR_W-1:0]   n_cc, n_ss, n_sc, n_cs;
    logic signed [e2q_pkg::TRIG_W-1:0]   r_cy, r_sy;
    // triple products, Q45
    logic signed [e2q_pkg::TRIPLE_W-1:0] r_cc_cy, r_ss_sy, r_sc_cy, r_cs_sy;
    logic signed [e2q_pkg::TRIPLE_W-1:0] r_cs_cy, r_sc_sy, r_cc_sy, r_ss_cy;
    logic signed [e2q_pkg::TRIPLE_W-1:0] n_cc_cy, n_ss_sy, n_sc_cy, n_cs_sy;
    logic signed [e2q_pkg::TRIPLE_W-1:0] n_cs_cy, n_sc_sy, n_cc_sy, n_ss_cy;
    // component sums
    logic signed [e2q_pkg::SUM_W-1:0]    r_sum_w, r_sum_x, r_sum_y, r_sum_z;
    logic signed [e2q_pkg::SUM_W-1:0]    n_sum_w, n_sum_x, n_sum_y, n_sum_z;
    // rounded components
    logic signed [e2q_pkg::RND_W-1:0]    r_rnd_w, r_rnd_x, r_rnd_y, r_rnd_z;
    e2q_pkg::t_out_word                  r_quat;
    e2q_pkg::t_out_word                  n_quat;

    function automatic logic signed [e2q_pkg::RND_W-1:0] round_q14(
        input logic signed [e2q_pkg::SUM_W-1:0] v
    );
        logic signed [e2q_pkg::SUM_W-1:0] biased;
        logic signed [e2q_pkg::SUM_W-1:0] half;
        half   = e2q_pkg::SUM_W'(64'sd1073741824);
        biased = v + (v[e2q_pkg::SUM_W-1] ? half - e2q_pkg::SUM_W'(1) : half);
        return biased[e2q_pkg::SUM_W-1:31];
    endfunction

    function automatic logic signed [e2q_pkg::QUAT_W-1:0] saturate(
        input logic signed [e2q_pkg::RND_W-1:0] v
    );
        logic signed [e2q_pkg::QUAT_W-1:0] r;
        priority if (v > e2q_pkg::RND_W'(e2q_pkg::QUAT_ONE)) begin
            r = e2q_pkg::QUAT_ONE;
        end else if (v < e2q_pkg::RND_W'(e2q_pkg::QUAT_NEG_ONE)) begin
            r = e2q_pkg::QUAT_NEG_ONE;
        end else begin
            r = v[e2q_pkg::QUAT_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        n_cc = i_roll.cos_q15 * i_pitch.cos_q15;
        n_ss = i_roll.sin_q15 * i_pitch.sin_q15;
        n_sc = i_roll.sin_q15 * i_pitch.cos_q15;
        n_cs = i_roll.cos_q15 * i_pitch.sin_q15;
    end

    always_comb begin
        n_cc_cy = r_cc * r_cy;
        n_ss_sy = r_ss * r_sy;
        n_sc_cy = r_sc * r_cy;
        n_cs_sy = r_cs * r_sy;
        n_cs_cy = r_cs * r_cy;
        n_sc_sy = r_sc * r_sy;
        n_cc_sy = r_cc * r_sy;
        n_ss_cy = r_ss * r_cy;
    end

    always_comb begin
        n_sum_w = r_cc_cy + r_ss_sy;
        n_sum_x = r_sc_cy - r_cs_sy;
        n_sum_y = r_cs_cy + r_sc_sy;
        n_sum_z = r_cc_sy - r_ss_cy;
    end

    always_comb begin
        n_quat.quat_w = saturate(r_rnd_w);
        n_quat.quat_x = saturate(r_rnd_x);
        n_quat.quat_y = saturate(r_rnd_y);
        n_quat.quat_z = saturate(r_rnd_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc    <= n_cc;
            r_ss    <= n_ss;
            r_sc    <= n_sc;
            r_cs    <= n_cs;
            r_cy    <= i_yaw.cos_q15;
            r_sy    <= i_yaw.sin_q15;
            r_cc_cy <= n_cc_cy;
            r_ss_sy <= n_ss_sy;
            r_sc_cy <= n_sc_cy;
            r_cs_sy <= n_cs_sy;
            r_cs_cy <= n_cs_cy;
            r_sc_sy <= n_sc_sy;
            r_cc_sy <= n_cc_sy;
            r_ss_cy <= n_ss_cy;
            r_sum_w <= n_sum_w;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_sum_z <= n_sum_z;
            r_rnd_w <= round_q14(r_sum_w);
            r_rnd_x <= round_q14(r_sum_x);
            r_rnd_y <= round_q14(r_sum_y);
            r_rnd_z <= round_q14(r_sum_z);
            r_quat  <= n_quat;
        end
    end

    assign o_quat = r_quat;

endmodule

[hw/rtl/euler_to_quaternion.sv]
// Top level of the Z-Y-X Euler angle to quaternion converter.
// Depends on e2q_pkg, e2q_cordic and e2q_product.
//
//   channel   direction   handshake                          word
//   in        sink        i_in_valid / o_in_ready            e2q_pkg::t_in_word
//   out       source      o_out_valid / i_out_ready          e2q_pkg::t_out_word
//
// Each word passes from acceptance to presentation through one fold register,
// eight CORDIC stages of two micro-rotations, one rounding register, then five
// stages of multiply, add, round and saturate. One word is accepted per cycle.
// The whole pipeline advances together whenever the output register is empty
// or its word is being taken, so a stall freezes every stage in place and blocks input.
// Reset (synchronous, active low) clears only the valid bits; data registers
// are left as they are.
module euler_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  e2q_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output e2q_pkg::t_out_word o_out_data
);

    // One valid bit per register stage, travelling alongside the data path.
    logic [e2q_pkg::TOTAL_LAT-1:0] r_valid;
    logic [e2q_pkg::TOTAL_LAT-1:0] n_valid;
    logic                          adv;

    e2q_pkg::t_trig yaw_trig;
    e2q_pkg::t_trig pitch_trig;
    e2q_pkg::t_trig roll_trig;

    // The pipeline moves whenever the last stage is free or being drained.
    assign adv        = !r_valid[e2q_pkg::TOTAL_LAT-1] || i_out_ready;
    assign o_in_ready = adv;
    assign o_out_valid = r_valid[e2q_pkg::TOTAL_LAT-1];

    always_comb begin
        n_valid = r_valid;
        if (adv) begin
            n_valid = {r_valid[e2q_pkg::TOTAL_LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Three identical half-angle sine/cosine pipelines, one per axis.
    e2q_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (i_in_data.yaw_angle),
        .o_trig  (yaw_trig)
    );

    e2q_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (i_in_data.pitch_angle),
        .o_trig  (pitch_trig)
    );

    e2q_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (i_in_data.roll_angle),
        .o_trig  (roll_trig)
    );

    // Products, sums, rounding and saturation; its last register is the output.
    e2q_product u_product (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_yaw   (yaw_trig),
        .i_pitch (pitch_trig),
        .i_roll  (roll_trig),
        .o_quat  (o_out_data)
    );

`ifndef SYNTH
    // Every presented component lies within the saturation limits.
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.quat_w <= e2q_pkg::QUAT_ONE) &&
            (o_out_data.quat_w >= e2q_pkg::QUAT_NEG_ONE) &&
            (o_out_data.quat_x <= e2q_pkg::QUAT_ONE) &&
            (o_out_data.quat_x >= e2q_pkg::QUAT_NEG_ONE) &&
            (o_out_data.quat_y <= e2q_pkg::QUAT_ONE) &&
            (o_out_data.quat_y >= e2q_pkg::QUAT_NEG_ONE) &&
            (o_out_data.quat_z <= e2q_pkg::QUAT_ONE) &&
            (o_out_data.quat_z >= e2q_pkg::QUAT_NEG_ONE))
        else $error("quaternion component outside saturation range");

    // The result is a unit quaternion to within a small rounding error.
    a_unit_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.quat_w * o_out_data.quat_w + o_out_data.quat_x * o_out_data.quat_x +
              o_out_data.quat_y * o_out_data.quat_y + o_out_data.quat_z * o_out_data.quat_z)
             >= 32'sd266338304) &&
            ((o_out_data.quat_w * o_out_data.quat_w + o_out_data.quat_x * o_out_data.quat_x +
              o_out_data.quat_y * o_out_data.quat_y + o_out_data.quat_z * o_out_data.quat_z)
             <= 32'sd270532608))
        else $error("quaternion norm far from one");

    // An empty output register never holds back the input side.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register empty");

    // While stalled, the pipeline neither gains nor loses words.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $countones(r_valid) == $countones($past(r_valid)))
        else $error("word count changed during a stall");
`endif

endmodule
